>>> rtl/dfa_string_recognizer_assert.svh
// Assertion macros used by the recognizer top level.
`ifndef DFA_STRING_RECOGNIZER_ASSERT_SVH
`define DFA_STRING_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define DFA_SR_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfa_sr: same-cycle check failed");

// Next-cycle implication, checked on the block clock outside reset.
`define DFA_SR_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfa_sr: next-cycle check failed");

`endif

>>> rtl/dfa_sr_pkg.sv
// Shared types and constants of the automaton recognizer.
package dfa_sr_pkg;

    localparam int OP_W        = 3;
    localparam int STATE_W     = 6;
    localparam int SYMBOL_W    = 8;
    localparam int COUNT_W     = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [SYMBOL_W-1:0]    TERMINATOR_SYMBOL = 8'd0;
    localparam logic [COUNT_W-1:0]     COUNT_RESET       = 7'd64;
    localparam logic [STATE_W-1:0]     START_RESET       = 6'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STATE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATE_COUNT   = 1'b1;

    // Operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_CHANGE = 3'd1,
        OP_DELETE = 3'd2,
        OP_MARK   = 3'd3,
        OP_UNMARK = 3'd4,
        OP_FEED   = 3'd5,
        OP_FINISH = 3'd6
    } t_op;

    // One transition table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } t_entry;

endpackage

>>> rtl/dfa_sr_clear.sv
// Post-reset sweep counter that walks every table address once.
module dfa_sr_clear #(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_busy,
    output logic [ADDR_W-1:0] o_addr
);

    logic              r_busy;
    logic [ADDR_W-1:0] r_idx;

    // Advance one entry a cycle, stop after the last address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + ADDR_W'(1);
            if (r_idx == {ADDR_W{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_idx;

endmodule

>>> rtl/dfa_sr_table.sv
// Transition table memory with registered read and write-to-read bypass.
module dfa_sr_table
    import dfa_sr_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_clr_busy,
    input  logic [ADDR_W-1:0] i_clr_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    t_entry            r_mem [DEPTH];
    t_entry            r_rd;
    logic              we;
    logic [ADDR_W-1:0] wa;
    t_entry            wd;

    // Clear sweep takes the write port while it runs
    always_comb begin
        we = i_clr_busy | i_wr_en;
        wa = i_clr_busy ? i_clr_addr : i_wr_addr;
        wd = i_clr_busy ? '0 : i_wr_data;
    end

    // Write, and read with the same-edge write forwarded
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd <= (we && (wa == i_rd_addr)) ? wd : r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> rtl/dfa_sr_accept_map.sv
// Accept-state bit memory with registered read.
module dfa_sr_accept_map #(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_clr_busy,
    input  logic [ADDR_W-1:0] i_clr_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic              o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic              r_mem [DEPTH];
    logic              r_rd;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic              wd;

    // Clear sweep takes the write port while it runs
    always_comb begin
        we = i_clr_busy | i_wr_en;
        wa = i_clr_busy ? i_clr_addr : i_wr_addr;
        wd = i_clr_busy ? 1'b0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> rtl/dfa_string_recognizer.sv
// Top level of the table-driven automaton recognizer.
//
// Input channel (i_valid / o_stall) carries one item per cycle: a table edit
// (add, change, delete), an accept-map edit (mark, unmark), a fed symbol or
// a string finish. Output channel (o_valid / i_stall) carries one result per
// finish item: o_accepted and o_dead.
// Throughput is one item per cycle while o_stall is low, feeds included: the registered table
// read picks the next state, which directly forms the next read address.
// A finish passes through the item register and then the result register.
// Table and accept-map edits take effect for the item right behind them.
// Reset runs a clearing pass over every table and accept-map address, during
// which o_stall is high; configuration writes are taken during the pass.
// Writing start_state also restarts the run in that state.
// A stalled result holds in the output register; other items keep flowing
// until a finish finds it full and stalled; that finish waits and stalls input.
module dfa_string_recognizer
    import dfa_sr_pkg::*;
#(
    parameter int STATE_COUNT_MAX = 64,
    parameter int ALPHABET_SIZE   = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [STATE_W-1:0]     i_from_state,
    input  logic [SYMBOL_W-1:0]    i_symbol,
    input  logic [STATE_W-1:0]     i_to_state,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_accepted,
    output logic                   o_dead,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ST_W   = $clog2(STATE_COUNT_MAX);
    localparam int SYM_AW = $clog2(ALPHABET_SIZE);
    localparam int ADDR_W = ST_W + SYM_AW;

    // Configuration and run state
    logic [STATE_W-1:0] r_start;
    logic [COUNT_W-1:0] r_count;
    logic [STATE_W-1:0] r_cur;
    logic [STATE_W-1:0] n_cur;
    logic               r_dead;
    logic               n_dead;

    // Item register
    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [SYMBOL_W-1:0] r_s1_sym;
    logic [STATE_W-1:0]  r_s1_to;
    logic                r_s1_rng;
    logic [ADDR_W-1:0]   r_s1_addr;

    // Result register
    logic r_out_valid;
    logic r_out_acc;
    logic r_out_dead;

    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;
    t_op               in_op;
    logic              in_fire;
    logic              in_rng;
    logic [STATE_W-1:0] rd_state;
    logic [ADDR_W-1:0] tbl_rd_addr;
    t_entry            tbl_rd;
    logic              tbl_we;
    t_entry            tbl_wd;
    logic              acc_we;
    logic              acc_wd;
    logic              acc_rd;
    logic              s1_finish;
    logic              s1_hold;
    logic              s1_fire;
    logic              feed_rng;
    logic              cur_rng;
    logic              out_acc;

    dfa_sr_clear #(
        .ADDR_W (ADDR_W)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    // Input side: decode and form the read addresses
    assign in_op     = t_op'(i_operation);
    assign s1_finish = r_s1_valid && (r_s1_op == OP_FINISH);
    assign s1_hold   = s1_finish && r_out_valid && i_stall;
    assign s1_fire   = r_s1_valid && !s1_hold;
    assign o_stall   = clr_busy || s1_hold;
    assign in_fire   = i_valid && !o_stall;
    assign in_rng    = (32'(i_from_state) < STATE_COUNT_MAX)
                    && (32'(i_symbol) < ALPHABET_SIZE);
    assign rd_state  = ((in_op == OP_FEED) || (in_op == OP_FINISH)) ? n_cur : i_from_state;
    assign tbl_rd_addr = {ST_W'(rd_state), SYM_AW'(i_symbol)};

    // Accept-map edits happen as the item is taken
    always_comb begin
        acc_we = 1'b0;
        acc_wd = 1'b0;
        if (in_fire) begin
            case (in_op)
                OP_MARK: begin
                    acc_we = ({1'b0, i_from_state} < r_count)
                          && (32'(i_from_state) < STATE_COUNT_MAX);
                    acc_wd = 1'b1;
                end
                OP_UNMARK: begin
                    acc_we = 32'(i_from_state) < STATE_COUNT_MAX;
                    acc_wd = 1'b0;
                end
                default: begin
                    acc_we = 1'b0;
                end
            endcase
        end
    end

    dfa_sr_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_clr_busy (clr_busy),
        .i_clr_addr (clr_addr),
        .i_wr_en    (tbl_we),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (tbl_wd),
        .i_rd_en    (in_fire),
        .i_rd_addr  (tbl_rd_addr),
        .o_rd_data  (tbl_rd)
    );

    dfa_sr_accept_map #(
        .ADDR_W (ST_W)
    ) u_accept (
        .i_clk      (i_clk),
        .i_clr_busy (clr_busy),
        .i_clr_addr (clr_addr[ST_W-1:0]),
        .i_wr_en    (acc_we),
        .i_wr_addr  (ST_W'(i_from_state)),
        .i_wr_data  (acc_wd),
        .i_rd_en    (in_fire),
        .i_rd_addr  (ST_W'(n_cur)),
        .o_rd_data  (acc_rd)
    );

    // Item stage: table writes, state step and result value
    assign feed_rng = (32'(r_cur) < STATE_COUNT_MAX) && (32'(r_s1_sym) < ALPHABET_SIZE);
    assign cur_rng  = 32'(r_cur) < STATE_COUNT_MAX;
    assign out_acc  = !r_dead && cur_rng && acc_rd;

    always_comb begin
        tbl_we = 1'b0;
        tbl_wd = '{valid: 1'b1, next: r_s1_to};
        n_cur  = r_cur;
        n_dead = r_dead;
        if (s1_fire) begin
            case (r_s1_op)
                OP_ADD: begin
                    tbl_we = r_s1_rng && !tbl_rd.valid;
                end
                OP_CHANGE: begin
                    tbl_we = r_s1_rng && tbl_rd.valid;
                end
                OP_DELETE: begin
                    tbl_we = r_s1_rng;
                    tbl_wd = '{valid: 1'b0, next: r_s1_to};
                end
                OP_FEED: begin
                    if (!r_dead && (r_s1_sym != TERMINATOR_SYMBOL)) begin
                        if (feed_rng && tbl_rd.valid) begin
                            n_cur = tbl_rd.next;
                        end else begin
                            n_dead = 1'b1;
                        end
                    end
                end
                OP_FINISH: begin
                    n_cur  = r_start;
                    n_dead = 1'b0;
                end
                default: begin
                    tbl_we = 1'b0;
                end
            endcase
        end
        // Start-state write restarts the run
        if (i_cfg_wr_en && (i_cfg_index == CFG_START_STATE)) begin
            n_cur  = i_cfg_data[STATE_W-1:0];
            n_dead = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= START_RESET;
            r_count     <= COUNT_RESET;
            r_cur       <= START_RESET;
            r_dead      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_dead <= n_dead;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_START_STATE) begin
                    r_start <= i_cfg_data[STATE_W-1:0];
                end
                if (i_cfg_index == CFG_STATE_COUNT) begin
                    r_count <= i_cfg_data;
                end
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && s1_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the item, load the result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op   <= in_op;
            r_s1_sym  <= i_symbol;
            r_s1_to   <= i_to_state;
            r_s1_rng  <= in_rng;
            r_s1_addr <= tbl_rd_addr;
        end
        if (s1_fire && s1_finish) begin
            r_out_acc  <= out_acc;
            r_out_dead <= r_dead;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;
    assign o_dead     = r_out_dead;

    `include "dfa_string_recognizer_assert.svh"

    `DFA_SR_CHECK_NEXT(a_finish_loads_result, s1_fire && s1_finish, r_out_valid)
    `DFA_SR_CHECK_NOW(a_dead_never_accepts, r_out_valid, !(o_accepted && o_dead))
    `DFA_SR_CHECK_NOW(a_no_item_during_clear, clr_busy, !r_s1_valid && !tbl_we)
    `DFA_SR_CHECK_NEXT(a_finish_restarts_run, s1_fire && s1_finish, (r_cur == r_start) && !r_dead)

endmodule
